### rtl/bra_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bra_pkg
// Shared types, sizes and codes of the resource allocator.
// ----------------------------------------------------------------------------
package bra_pkg;

    localparam int MAX_CUSTOMERS = 8;
    localparam int MAX_RESOURCES = 4;
    localparam int UNIT_BITS     = 8;
    localparam int CUST_BITS     = 3;
    localparam int RES_BITS      = 2;
    localparam int ROW_BITS      = MAX_RESOURCES * UNIT_BITS;

    typedef logic [UNIT_BITS-1:0] t_unit;
    typedef logic [ROW_BITS-1:0]  t_row;

    localparam logic [2:0] OP_REQUEST = 3'd0;
    localparam logic [2:0] OP_RELEASE = 3'd1;
    localparam logic [2:0] OP_SET_MAX = 3'd2;
    localparam logic [2:0] OP_SET_AVL = 3'd3;
    localparam logic [2:0] OP_QUERY   = 3'd4;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_BAD_CUST  = 3'd1;
    localparam logic [2:0] ST_OVER_NEED = 3'd2;
    localparam logic [2:0] ST_OVER_AVL  = 3'd3;
    localparam logic [2:0] ST_UNSAFE    = 3'd4;

    localparam logic REG_CUSTOMERS = 1'b0;
    localparam logic REG_RESOURCES = 1'b1;

endpackage
`default_nettype wire

### rtl/bankers_resource_allocator.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bankers_resource_allocator
// Banker's-algorithm allocator: claim and allocation rows in one RAM each,
// a sequencer for checks, grants, releases and the safety scan.
// ----------------------------------------------------------------------------
// channel   dir  handshake               payload
// s_axis    in   s_axis_tvalid/tready    tdata: req_type, customer, amounts
// m_axis    out  m_axis_tvalid/tready    tdata: status, sequence; tlast
// cfg       in   i_cfg_valid/o_cfg_ready index, data
//
// One item at a time. A request reads its row (S_RD) and checks it (S_CHK),
// then the safety scan reads one customer row at a time through the RAM
// port (S_SCANR, S_SCANE) until every active customer is placed or none fits.
// Synchronous active-low reset; RAM contents are cleared by a pass over all
// rows after reset, during which no item is taken. A stalled output holds the
// sequencer; the input is taken only when the block is idle.
// ----------------------------------------------------------------------------
module bankers_resource_allocator (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        s_axis_tvalid,
    output logic       s_axis_tready,
    // [2:0] req_type, [5:3] customer, [13:6] amount_0, [21:14] amount_1,
    // [29:22] amount_2, [37:30] amount_3, [39:38] zero
    input  wire [39:0] s_axis_tdata,
    output logic       m_axis_tvalid,
    input  wire        m_axis_tready,
    // [2:0] status, [5:3] sequence_customer, [7:6] zero
    output logic [7:0] m_axis_tdata,
    output logic       m_axis_tlast,
    input  wire        i_cfg_valid,
    output logic       o_cfg_ready,
    input  wire        i_cfg_index,
    input  wire [3:0]  i_cfg_data
);
    localparam int NC = bra_pkg::MAX_CUSTOMERS;
    localparam int NR = bra_pkg::MAX_RESOURCES;
    localparam int UB = bra_pkg::UNIT_BITS;
    localparam int CB = bra_pkg::CUST_BITS;

    typedef enum logic [9:0] {
        S_CLEAR = 10'b0000000001, S_IDLE  = 10'b0000000010,
        S_RD    = 10'b0000000100, S_CHK   = 10'b0000001000,
        S_SCANR = 10'b0000010000, S_SCANE = 10'b0000100000,
        S_DONE  = 10'b0001000000, S_OUT   = 10'b0010000000,
        S_SEQ   = 10'b0100000000, S_WB    = 10'b1000000000
    } t_state;

    t_state r_st, n_st;
    logic [3:0] r_ncust;
    logic [2:0] r_nres;
    bra_pkg::t_row mem_max [NC];
    bra_pkg::t_row mem_alc [NC];
    bra_pkg::t_row r_rd_max, r_rd_alc;
    bra_pkg::t_unit r_avl [NR];
    bra_pkg::t_unit r_work [NR];
    bra_pkg::t_unit r_amt [NR];
    logic [2:0] r_op;
    logic [CB-1:0] r_cust;
    logic [NC-1:0] r_done;
    logic [CB-1:0] r_order [NC];
    logic [CB-1:0] r_scan;
    logic [3:0] r_found;
    logic r_picked;
    logic [CB-1:0] r_k;
    logic [2:0] r_status;
    bra_pkg::t_row r_pre_alc;
    logic [CB-1:0] r_clr;

    // clamped register values
    logic [3:0] nc_eff;
    logic [2:0] nr_eff;
    always_comb begin
        nc_eff = (r_ncust == 4'd0) ? 4'd1 : (r_ncust > 4'(NC)) ? 4'(NC) : r_ncust;
        nr_eff = (r_nres == 3'd0) ? 3'd1 : (r_nres > 3'(NR)) ? 3'(NR) : r_nres;
    end

    // per-column view of the read row
    bra_pkg::t_unit rmax [NR];
    bra_pkg::t_unit ralc [NR];
    bra_pkg::t_unit need [NR];
    logic over_need, over_avl, fits;
    always_comb begin
        over_need = 1'b0;
        over_avl  = 1'b0;
        fits      = 1'b1;
        for (int r = 0; r < NR; r++) begin
            rmax[r] = r_rd_max[r*UB +: UB];
            ralc[r] = r_rd_alc[r*UB +: UB];
            need[r] = (rmax[r] > ralc[r]) ? rmax[r] - ralc[r] : '0;
            if (3'(r) < nr_eff) begin
                if (r_amt[r] > need[r]) over_need = 1'b1;
                if (r_amt[r] > r_avl[r]) over_avl = 1'b1;
                if (need[r] > r_work[r]) fits = 1'b0;
            end
        end
    end

    logic in_go, out_go, scan_last;
    assign s_axis_tready = (r_st == S_IDLE);
    assign o_cfg_ready   = (r_st == S_IDLE) || (r_st == S_CLEAR);
    assign in_go  = s_axis_tvalid && s_axis_tready;
    assign out_go = m_axis_tvalid && m_axis_tready;
    assign scan_last = ({1'b0, r_scan} + 4'd1 >= nc_eff);

    // output
    assign m_axis_tvalid = (r_st == S_OUT) || (r_st == S_SEQ);
    assign m_axis_tlast  = (r_st == S_OUT) ||
                           ({1'b0, r_k} + 4'd1 == nc_eff);
    assign m_axis_tdata  = (r_st == S_SEQ) ? {2'b00, r_order[r_k], bra_pkg::ST_OK}
                                           : {2'b00, 3'b000, r_status};

    // sequencer
    always_comb begin
        n_st = r_st;
        case (r_st)
            S_CLEAR: if (r_clr == CB'(NC-1)) n_st = S_IDLE;
            S_IDLE: begin
                if (in_go) begin
                    if (s_axis_tdata[2:0] <= bra_pkg::OP_SET_MAX &&
                        {1'b0, s_axis_tdata[5:3]} >= nc_eff) n_st = S_OUT;
                    else if (s_axis_tdata[2:0] == bra_pkg::OP_SET_AVL ||
                             s_axis_tdata[2:0] == bra_pkg::OP_SET_MAX) n_st = S_OUT;
                    else if (s_axis_tdata[2:0] == bra_pkg::OP_QUERY) n_st = S_SCANR;
                    else if (s_axis_tdata[2:0] <= bra_pkg::OP_RELEASE) n_st = S_RD;
                end
            end
            S_RD:  n_st = S_CHK;
            S_CHK: begin
                if (r_op == bra_pkg::OP_RELEASE) n_st = S_OUT;
                else if (over_need || over_avl) n_st = S_OUT;
                else n_st = S_SCANR;
            end
            S_SCANR: n_st = S_SCANE;
            S_SCANE: begin
                if (!r_done[r_scan] && fits) begin
                    if (r_found + 4'd1 == nc_eff) n_st = S_DONE;
                    else n_st = S_SCANR;
                end else if (scan_last && !r_picked) n_st = S_DONE;
                else n_st = S_SCANR;
            end
            S_DONE: begin
                if (r_op == bra_pkg::OP_QUERY && r_found == nc_eff) n_st = S_SEQ;
                else if (r_op == bra_pkg::OP_REQUEST && r_found != nc_eff) n_st = S_WB;
                else n_st = S_OUT;
            end
            S_WB:  n_st = S_OUT;
            S_OUT: if (out_go) n_st = S_IDLE;
            S_SEQ: if (out_go && ({1'b0, r_k} + 4'd1 == nc_eff)) n_st = S_IDLE;
            default: n_st = S_IDLE;
        endcase
    end

    // one row write per cycle to each RAM
    logic mem_we;
    logic [CB-1:0] mem_wa;
    bra_pkg::t_row wmax, walc;
    logic wmax_en;
    always_comb begin
        mem_we  = 1'b0;
        wmax_en = 1'b0;
        mem_wa  = r_cust;
        wmax    = '0;
        walc    = r_rd_alc;
        if (r_st == S_CLEAR) begin
            mem_we = 1'b1; wmax_en = 1'b1; mem_wa = r_clr; walc = '0;
        end else if (in_go && s_axis_tdata[2:0] == bra_pkg::OP_SET_MAX &&
                     {1'b0, s_axis_tdata[5:3]} < nc_eff) begin
            mem_we = 1'b1; wmax_en = 1'b1; mem_wa = s_axis_tdata[5:3];
            wmax = s_axis_tdata[37:6]; walc = '0;
        end else if (r_st == S_CHK && (r_op == bra_pkg::OP_RELEASE ||
                     !(over_need || over_avl))) begin
            mem_we = 1'b1;
            for (int r = 0; r < NR; r++) begin
                if (3'(r) < nr_eff) begin
                    if (r_op == bra_pkg::OP_RELEASE)
                        walc[r*UB +: UB] = (r_amt[r] > ralc[r]) ? '0 : ralc[r] - r_amt[r];
                    else
                        walc[r*UB +: UB] = ralc[r] + r_amt[r];
                end
            end
        end else if (r_st == S_WB) begin
            // roll back the tentative grant to the saved pre-grant row
            mem_we = 1'b1;
            walc   = r_pre_alc;
        end
    end

    logic [CB-1:0] raddr;
    always_comb begin
        raddr = r_scan;
        if (r_st == S_IDLE) raddr = s_axis_tdata[5:3];
    end

    // RAMs
    always_ff @(posedge i_clk) begin
        if (mem_we) mem_alc[mem_wa] <= walc;
        if (wmax_en) mem_max[mem_wa] <= wmax;
        if (r_st == S_IDLE || r_st == S_SCANR) begin
            r_rd_max <= mem_max[raddr];
            r_rd_alc <= mem_alc[raddr];
        end
    end

    // control and data registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_CLEAR;
            r_clr <= '0;
            r_ncust <= 4'd8;
            r_nres <= 3'd4;
            for (int r = 0; r < NR; r++) r_avl[r] <= '0;
        end else begin
            r_st <= n_st;
            if (r_st == S_CLEAR) r_clr <= r_clr + CB'(1);
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == bra_pkg::REG_CUSTOMERS) r_ncust <= i_cfg_data;
                else r_nres <= i_cfg_data[2:0];
            end
            if (in_go) begin
                r_op   <= s_axis_tdata[2:0];
                r_cust <= s_axis_tdata[5:3];
                for (int r = 0; r < NR; r++) r_amt[r] <= s_axis_tdata[6+r*UB +: UB];
                if (s_axis_tdata[2:0] <= bra_pkg::OP_SET_MAX &&
                    {1'b0, s_axis_tdata[5:3]} >= nc_eff)
                    r_status <= bra_pkg::ST_BAD_CUST;
                else begin
                    r_status <= bra_pkg::ST_OK;
                    if (s_axis_tdata[2:0] == bra_pkg::OP_SET_AVL)
                        for (int r = 0; r < NR; r++)
                            r_avl[r] <= s_axis_tdata[6+r*UB +: UB];
                end
                r_done <= '0;
                r_found <= '0;
                r_scan <= '0;
                r_picked <= 1'b0;
                r_k <= '0;
                for (int r = 0; r < NR; r++) r_work[r] <= r_avl[r];
            end
            if (r_st == S_CHK) begin
                if (r_op == bra_pkg::OP_RELEASE) begin
                    for (int r = 0; r < NR; r++)
                        if (3'(r) < nr_eff) begin
                            logic [UB:0] s;
                            s = {1'b0, r_avl[r]} +
                                {1'b0, (r_amt[r] > ralc[r]) ? ralc[r] : r_amt[r]};
                            r_avl[r] <= s[UB] ? '1 : s[UB-1:0];
                        end
                end else if (over_need) r_status <= bra_pkg::ST_OVER_NEED;
                else if (over_avl) r_status <= bra_pkg::ST_OVER_AVL;
                else
                    for (int r = 0; r < NR; r++)
                        if (3'(r) < nr_eff) begin
                            r_avl[r]  <= r_avl[r] - r_amt[r];
                            r_work[r] <= r_avl[r] - r_amt[r];
                        end
            end
            if (r_st == S_SCANE) begin
                if (!r_done[r_scan] && fits) begin
                    r_done[r_scan] <= 1'b1;
                    r_order[r_found[CB-1:0]] <= r_scan;
                    r_found <= r_found + 4'd1;
                    // work saturates: any need fits once it reaches full scale
                    for (int r = 0; r < NR; r++)
                        if (3'(r) < nr_eff) begin
                            logic [UB:0] w;
                            w = {1'b0, r_work[r]} + {1'b0, ralc[r]};
                            r_work[r] <= w[UB] ? '1 : w[UB-1:0];
                        end
                    r_picked <= 1'b0;
                    r_scan <= '0;
                end else if (scan_last) begin
                    r_scan <= '0;
                    r_picked <= 1'b0;
                end else begin
                    r_scan <= r_scan + CB'(1);
                end
            end
            if (r_st == S_DONE && r_found != nc_eff) begin
                r_status <= bra_pkg::ST_UNSAFE;
                if (r_op == bra_pkg::OP_REQUEST) begin
                    for (int r = 0; r < NR; r++)
                        if (3'(r) < nr_eff) r_avl[r] <= r_avl[r] + r_amt[r];
                end
            end
            if (r_st == S_SEQ && out_go) r_k <= r_k + CB'(1);
        end
    end

    // rollback needs the pre-grant row of the customer
    always_ff @(posedge i_clk) begin
        if (r_st == S_CHK) r_pre_alc <= r_rd_alc;
    end

    // assertions
    a_one_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready |-> !m_axis_tvalid) else $error("input open while output busy");
    a_seq_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == S_SEQ) |-> (r_found == nc_eff)) else $error("sequence incomplete");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata))
        else $error("output changed under stall");
endmodule
`default_nettype wire

### tb/bra_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bra_checker
// Watches the request, result and register channels of the allocator, keeps
// its own copy of the allocation tables, predicts every result and compares
// each result transfer against the oldest prediction.
// ----------------------------------------------------------------------------
module bra_checker
    import bra_pkg::*;
(
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_req_valid,
    input  wire        i_req_ready,
    input  wire [39:0] i_req_data,
    input  wire        i_res_valid,
    input  wire        i_res_ready,
    input  wire [7:0]  i_res_data,
    input  wire        i_res_last,
    input  wire        i_cfg_valid,
    input  wire        i_cfg_ready,
    input  wire        i_cfg_index,
    input  wire [3:0]  i_cfg_data,
    output int         o_errors,
    output int         o_pending,
    output int         o_results,
    output int         o_grants,
    output int         o_denials
);

    typedef struct packed {
        logic [2:0] status;
        logic [2:0] seq_cust;
        logic       last;
    } t_result;

    t_result     expected_results[$];
    logic [3:0]  cust_reg;
    logic [2:0]  res_reg;
    int unsigned avail[MAX_RESOURCES];
    int unsigned claim[MAX_CUSTOMERS][MAX_RESOURCES];
    int unsigned alloc[MAX_CUSTOMERS][MAX_RESOURCES];

    assign o_pending = expected_results.size();

    function automatic int unsigned num_cust();
        int unsigned n;
        n = cust_reg;
        if (n < 1) n = 1;
        if (n > MAX_CUSTOMERS) n = MAX_CUSTOMERS;
        return n;
    endfunction

    function automatic int unsigned num_res();
        int unsigned n;
        n = res_reg;
        if (n < 1) n = 1;
        if (n > MAX_RESOURCES) n = MAX_RESOURCES;
        return n;
    endfunction

    function automatic int unsigned need(int unsigned c, int unsigned r);
        return claim[c][r] > alloc[c][r] ? claim[c][r] - alloc[c][r] : 0;
    endfunction

    // Full safety scan: lowest-index unfinished customer that fits, repeated
    function automatic bit safe_order(output int unsigned order[MAX_CUSTOMERS]);
        int unsigned work[MAX_RESOURCES];
        bit          finished[MAX_CUSTOMERS];
        int unsigned nc, nr, found;
        bit          picked, fits;
        nc = num_cust();
        nr = num_res();
        found = 0;
        for (int r = 0; r < MAX_RESOURCES; r++) work[r] = avail[r];
        for (int c = 0; c < MAX_CUSTOMERS; c++) begin
            finished[c] = 0;
            order[c] = 0;
        end
        while (found < nc) begin
            picked = 0;
            for (int c = 0; c < nc && !picked; c++) begin
                fits = !finished[c];
                for (int r = 0; r < nr; r++)
                    if (need(c, r) > work[r]) fits = 0;
                if (fits) begin
                    for (int r = 0; r < nr; r++) work[r] += alloc[c][r];
                    finished[c] = 1;
                    order[found] = c;
                    found++;
                    picked = 1;
                end
            end
            if (!picked) return 0;
        end
        return 1;
    endfunction

    function automatic void push_status(logic [2:0] st);
        expected_results.push_back('{status: st, seq_cust: 3'd0, last: 1'b1});
    endfunction

    // Predict the results of one request transfer and update the tables
    function automatic void predict_request(logic [39:0] d);
        logic [2:0]  op;
        int unsigned c, nc, nr;
        int unsigned amt[MAX_RESOURCES];
        int unsigned order[MAX_CUSTOMERS];
        int unsigned give;
        logic [2:0]  st;
        op = d[2:0];
        c  = d[5:3];
        nc = num_cust();
        nr = num_res();
        for (int r = 0; r < MAX_RESOURCES; r++) amt[r] = d[6+8*r +: 8];
        if (op <= OP_SET_MAX && c >= nc) begin
            push_status(ST_BAD_CUST);
            o_denials++;
            return;
        end
        case (op)
            OP_REQUEST: begin
                st = ST_OK;
                for (int r = 0; r < nr; r++)
                    if (amt[r] > need(c, r)) st = ST_OVER_NEED;
                if (st == ST_OK)
                    for (int r = 0; r < nr; r++)
                        if (amt[r] > avail[r]) st = ST_OVER_AVL;
                if (st == ST_OK) begin
                    for (int r = 0; r < nr; r++) begin
                        avail[r] -= amt[r];
                        alloc[c][r] += amt[r];
                    end
                    if (!safe_order(order)) begin
                        for (int r = 0; r < nr; r++) begin
                            avail[r] += amt[r];
                            alloc[c][r] -= amt[r];
                        end
                        st = ST_UNSAFE;
                    end
                end
                if (st == ST_OK) o_grants++;
                else o_denials++;
                push_status(st);
            end
            OP_RELEASE: begin
                for (int r = 0; r < nr; r++) begin
                    give = amt[r] > alloc[c][r] ? alloc[c][r] : amt[r];
                    alloc[c][r] -= give;
                    avail[r] = (avail[r] + give > 255) ? 255 : avail[r] + give;
                end
                push_status(ST_OK);
            end
            OP_SET_MAX: begin
                for (int r = 0; r < MAX_RESOURCES; r++) begin
                    claim[c][r] = amt[r];
                    alloc[c][r] = 0;
                end
                push_status(ST_OK);
            end
            OP_SET_AVL: begin
                for (int r = 0; r < MAX_RESOURCES; r++) avail[r] = amt[r];
                push_status(ST_OK);
            end
            OP_QUERY: begin
                if (!safe_order(order)) push_status(ST_UNSAFE);
                else
                    for (int k = 0; k < nc; k++)
                        expected_results.push_back('{status: ST_OK,
                            seq_cust: order[k][2:0], last: (k + 1 == nc)});
            end
            default: ;
        endcase
    endfunction

    always @(posedge i_clk) begin
        t_result got, want;
        if (!i_rst_n) begin
            cust_reg  <= 4'd8;
            res_reg   <= 3'd4;
            o_errors  <= 0;
            o_results <= 0;
            o_grants  = 0;
            o_denials = 0;
            expected_results.delete();
            for (int r = 0; r < MAX_RESOURCES; r++) avail[r] = 0;
            for (int c = 0; c < MAX_CUSTOMERS; c++)
                for (int r = 0; r < MAX_RESOURCES; r++) begin
                    claim[c][r] = 0;
                    alloc[c][r] = 0;
                end
        end else begin
            // result side first: it belongs to items taken earlier
            if (i_res_valid && i_res_ready) begin
                got = '{status: i_res_data[2:0], seq_cust: i_res_data[5:3],
                        last: i_res_last};
                o_results <= o_results + 1;
                if (expected_results.size() == 0) begin
                    if (o_errors < 10)
                        $display("%0t: unexpected result status=%0d seq=%0d last=%0d",
                                 $realtime, got.status, got.seq_cust, got.last);
                    o_errors <= o_errors + 1;
                end else begin
                    want = expected_results.pop_front();
                    if (got !== want || i_res_data[7:6] !== 2'b00) begin
                        if (o_errors < 10)
                            $display(
                                "%0t: expected st=%0d seq=%0d last=%0d, got st=%0d seq=%0d last=%0d",
                                $realtime, want.status, want.seq_cust, want.last,
                                got.status, got.seq_cust, got.last);
                        o_errors <= o_errors + 1;
                    end
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == REG_CUSTOMERS) cust_reg <= i_cfg_data;
                else res_reg <= i_cfg_data[2:0];
            end
            if (i_req_valid && i_req_ready) predict_request(i_req_data);
        end
    end

endmodule

### tb/tb_bankers_resource_allocator.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_bankers_resource_allocator
// Drives the allocator with directed and random request sequences under
// several customer and resource counts, with bursty input and a stalling
// result side; the checker module predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_bankers_resource_allocator;
    import bra_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    wire         s_axis_tready;
    logic [39:0] s_axis_tdata;
    wire         m_axis_tvalid;
    logic        m_axis_tready;
    wire  [7:0]  m_axis_tdata;
    wire         m_axis_tlast;
    logic        i_cfg_valid;
    wire         o_cfg_ready;
    logic        i_cfg_index;
    logic [3:0]  i_cfg_data;

    int errors, pending, results, grants, denials;
    int items_sent, idle_cycles;
    bit timed_out;
    int stall_mode;

    bankers_resource_allocator dut (.*);

    bra_checker checker_inst (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_req_valid(s_axis_tvalid), .i_req_ready(s_axis_tready),
        .i_req_data(s_axis_tdata),
        .i_res_valid(m_axis_tvalid), .i_res_ready(m_axis_tready),
        .i_res_data(m_axis_tdata), .i_res_last(m_axis_tlast),
        .i_cfg_valid(i_cfg_valid), .i_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .o_errors(errors), .o_pending(pending), .o_results(results),
        .o_grants(grants), .o_denials(denials)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Result side stalls: a mode that changes now and then, including no stall
    initial begin
        m_axis_tready = 1'b0;
        stall_mode = 0;
        forever begin
            @(posedge i_clk);
            if ($urandom_range(0, 63) == 0) stall_mode = $urandom_range(0, 3);
            case (stall_mode)
                0: m_axis_tready <= 1'b1;
                1: m_axis_tready <= ($urandom_range(0, 3) != 0);
                2: m_axis_tready <= ($urandom_range(0, 1) != 0);
                default: m_axis_tready <= ($urandom_range(0, 7) == 0);
            endcase
        end
    end

    // Watchdog: cycles with no transfer on any channel
    initial begin
        timed_out = 0;
        idle_cycles = 0;
        forever begin
            @(posedge i_clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                || (i_cfg_valid && o_cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog expired, %0d results outstanding", pending);
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    function automatic logic [39:0] pack_item(logic [2:0] op, int cust,
                                              int a0, int a1, int a2, int a3);
        return {2'b00, 8'(a3), 8'(a2), 8'(a1), 8'(a0), 3'(cust), op};
    endfunction

    int burst_left;

    // One request transfer; a random gap may come first, bursts keep valid high
    task automatic send_item(logic [39:0] d);
        if (burst_left == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
            burst_left = $urandom_range(1, 8);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= d;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        burst_left--;
        items_sent++;
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (150) @(posedge i_clk);
    endtask

    // Register write; valid drops after it, keeping back-to-back writes apart
    task automatic write_reg(logic idx, logic [3:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic int rand_amt(int hi);
        return int'($urandom_range(0, hi));
    endfunction

    // Allocation scenario with random content, including bad customers and unknown operations
    task automatic run_scenario(int n_items, int nc);
        int pick, cust;
        logic [2:0] op;
        send_item(pack_item(OP_SET_AVL, 0, rand_amt(40), rand_amt(40),
                            rand_amt(40), rand_amt(40)));
        for (int c = 0; c < nc; c++)
            send_item(pack_item(OP_SET_MAX, c, rand_amt(30), rand_amt(30),
                                rand_amt(30), rand_amt(30)));
        for (int i = 0; i < n_items; i++) begin
            pick = $urandom_range(0, 99);
            cust = (pick < 95) ? int'($urandom_range(0, nc - 1))
                               : int'($urandom_range(0, 7));
            if (pick < 50) op = OP_REQUEST;
            else if (pick < 65) op = OP_RELEASE;
            else if (pick < 80) op = OP_QUERY;
            else if (pick < 86) op = OP_SET_MAX;
            else if (pick < 90) op = OP_SET_AVL;
            else op = 3'($urandom_range(0, 7));
            if (op == OP_REQUEST)
                send_item(pack_item(op, cust, rand_amt(6), rand_amt(6),
                                    rand_amt(6), rand_amt(6)));
            else if (pick >= 97)
                send_item({2'b00, 32'($urandom), 3'(cust), op});
            else
                send_item(pack_item(op, cust, rand_amt(30), rand_amt(30),
                                    rand_amt(30), rand_amt(30)));
        end
    endtask

    initial begin
        int nc;
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        i_cfg_valid   <= 1'b0;
        i_cfg_index   <= REG_CUSTOMERS;
        i_cfg_data    <= '0;
        items_sent = 0;
        burst_left = 0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: extremes, every operation, denials, unsafe and saturation
        send_item(pack_item(OP_QUERY, 0, 0, 0, 0, 0));
        send_item(pack_item(OP_SET_AVL, 0, 255, 255, 255, 255));
        send_item(pack_item(OP_SET_MAX, 7, 255, 255, 255, 255));
        send_item(pack_item(OP_REQUEST, 7, 255, 255, 255, 255));
        send_item(pack_item(OP_RELEASE, 7, 255, 255, 255, 255));
        send_item(pack_item(OP_RELEASE, 7, 255, 255, 255, 255));
        send_item(pack_item(OP_SET_AVL, 0, 5, 5, 5, 5));
        send_item(pack_item(OP_SET_MAX, 0, 10, 10, 10, 10));
        send_item(pack_item(OP_SET_MAX, 1, 10, 10, 10, 10));
        send_item(pack_item(OP_REQUEST, 0, 11, 0, 0, 0));
        send_item(pack_item(OP_REQUEST, 0, 0, 6, 0, 0));
        send_item(pack_item(OP_REQUEST, 0, 4, 4, 4, 4));
        send_item(pack_item(OP_QUERY, 0, 0, 0, 0, 0));
        send_item(pack_item(OP_REQUEST, 1, 1, 1, 1, 1));
        send_item(pack_item(OP_SET_MAX, 0, 0, 0, 0, 0));
        send_item(pack_item(OP_QUERY, 0, 0, 0, 0, 0));
        send_item(pack_item(3'd5, 0, 0, 0, 0, 0));
        send_item(pack_item(3'd7, 7, 255, 255, 255, 255));
        drain();

        write_reg(REG_CUSTOMERS, 4'd1);
        write_reg(REG_RESOURCES, 4'd1);
        send_item(pack_item(OP_REQUEST, 3, 1, 0, 0, 0));
        send_item(pack_item(OP_SET_MAX, 0, 3, 170, 85, 1));
        send_item(pack_item(OP_REQUEST, 0, 3, 255, 0, 0));
        send_item(pack_item(OP_QUERY, 0, 0, 0, 0, 0));
        drain();

        // Random phases under several register settings, extremes included
        write_reg(REG_CUSTOMERS, 4'd8);
        write_reg(REG_RESOURCES, 4'd4);
        run_scenario(16, 8);
        drain();
        write_reg(REG_CUSTOMERS, 4'd3);
        write_reg(REG_RESOURCES, 4'd2);
        run_scenario(12, 3);
        drain();
        write_reg(REG_CUSTOMERS, 4'd15);
        write_reg(REG_RESOURCES, 4'd7);
        run_scenario(12, 8);
        drain();
        write_reg(REG_CUSTOMERS, 4'd0);
        write_reg(REG_RESOURCES, 4'd0);
        run_scenario(6, 1);
        drain();
        nc = int'($urandom_range(2, 8));
        write_reg(REG_CUSTOMERS, nc[3:0]);
        write_reg(REG_RESOURCES, 4'($urandom_range(1, 4)));
        run_scenario(12, nc);
        drain();

        $display("covered %0d requests, %0d results, %0d grants, %0d denials",
                 items_sent, results, grants, denials);
        $display("register settings from 0 to 15 customers and 0 to 7 resource types");
        if (errors == 0 && pending == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("%0d mismatches, %0d results missing", errors, pending);
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
